/* rtl/core/smcn_pkg.sv */
package smcn_pkg;

   localparam int CHANNELS    = 6;
   localparam int SAMPLE_BITS = 10;

   localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CHANNEL_W  = 3;
   localparam int CMD_W      = 2;
   localparam int VALUE_W    = 21;
   localparam int EXT_W      = 10;
   localparam int NUM_W      = 2 * SAMPLE_BITS;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE  = '1;
   localparam logic [SAMPLE_BITS-1:0] CAL_RESET   = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
   localparam logic [SAMPLE_BITS-1:0] PERCENT_TOP = SAMPLE_BITS'(100);

   localparam logic [CMD_W-1:0] CMD_TRACK = 2'd0;
   localparam logic [CMD_W-1:0] CMD_NORM  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

   localparam logic [1:0] SCALE_RAW  = 2'd0;
   localparam logic [1:0] SCALE_PCT  = 2'd1;
   localparam logic [1:0] SCALE_FULL = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_OUTPUT_SCALE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_INVERT_MASK  = 2'd1;

   localparam logic [1:0]          SCALE_RESET = SCALE_PCT;
   localparam logic [CHANNELS-1:0] MASK_RESET  = CHANNELS'(7);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] low;
      logic [SAMPLE_BITS-1:0] high;
   } cal_pair_type;

   typedef struct packed {
      logic         en;
      cal_pair_type pair;
   } cal_wr_type;

endpackage

/* rtl/core/smcn_cal_store.sv */
module smcn_cal_store (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [smcn_pkg::CH_IDX_W-1:0]  idx,
   input  smcn_pkg::cal_wr_type           wr,
   output smcn_pkg::cal_pair_type         rd
);

   smcn_pkg::cal_pair_type cal_ff [smcn_pkg::CHANNELS];

   assign rd = cal_ff[idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < smcn_pkg::CHANNELS; i++) begin
            cal_ff[i].low  <= smcn_pkg::CAL_RESET;
            cal_ff[i].high <= smcn_pkg::CAL_RESET;
         end
      end else if (wr.en) begin
         cal_ff[idx] <= wr.pair;
      end
   end

endmodule

/* rtl/core/smcn_div.sv */
module smcn_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [smcn_pkg::NUM_W-1:0]         dividend,
   input  logic [smcn_pkg::SAMPLE_BITS-1:0]   divisor,
   output logic                               done,
   output logic [smcn_pkg::NUM_W-1:0]         quotient
);

   localparam int SB    = smcn_pkg::SAMPLE_BITS;
   localparam int NW    = smcn_pkg::NUM_W;
   localparam int CNT_W = $clog2(NW + 1);

   logic [NW-1:0]    quo_ff,  quo_in;
   logic [SB-1:0]    rem_ff,  rem_in;
   logic [SB-1:0]    dvs_ff,  dvs_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [SB:0]      shifted;
   logic [SB:0]      trial;
   logic             fits;

   // one restoring step per cycle, dividend bits shift out as quotient bits shift in
   always_comb begin
      shifted  = {rem_ff, quo_ff[NW-1]};
      trial    = shifted - {1'b0, dvs_ff};
      fits     = shifted >= {1'b0, dvs_ff};
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         quo_in   = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
         count_in = CNT_W'(NW);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[NW-2:0], fits};
         rem_in   = fits ? trial[SB-1:0] : shifted[SB-1:0];
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/core/sensor_min_max_calibrate_normalize.sv */
// Sequence: a track, load, raw, zero-span or no-op request is registered on acceptance, then
// loaded into the response registers once they are free; a rescale request first passes
// through multiply, a 20-step serial divide (one quotient bit per cycle) and sign fix. Not
// ready while a request is in work: a new request is taken only after its response is loaded.
// Reset (synchronous, active high): all channel extremes 512, output_scale 1, invert_mask 7,
// no response pending.
module sensor_min_max_calibrate_normalize (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [smcn_pkg::CMD_W-1:0]             req_cmd,
   input  logic [smcn_pkg::CHANNEL_W-1:0]         req_channel,
   input  logic [smcn_pkg::SAMPLE_BITS-1:0]       req_sample,
   input  logic [smcn_pkg::SAMPLE_BITS-1:0]       req_load_low,
   input  logic [smcn_pkg::SAMPLE_BITS-1:0]       req_load_high,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [smcn_pkg::VALUE_W-1:0]    rsp_value,
   output logic                                   rsp_zero_span,
   output logic [smcn_pkg::EXT_W-1:0]             rsp_chan_low,
   output logic [smcn_pkg::EXT_W-1:0]             rsp_chan_high,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [smcn_pkg::CSR_ADDR_W-1:0]        csr_index,
   input  logic [smcn_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int SB = smcn_pkg::SAMPLE_BITS;
   localparam int VW = smcn_pkg::VALUE_W;
   localparam int EW = smcn_pkg::EXT_W;
   localparam int NW = smcn_pkg::NUM_W;

   smcn_pkg::state_type state_ff, state_in;

   logic [1:0]                  scale_ff;
   logic [smcn_pkg::CHANNELS-1:0] mask_ff;

   logic signed [VW-1:0] res_value_ff, res_value_in;
   logic                 res_zero_ff,  res_zero_in;
   logic [EW-1:0]        res_low_ff,   res_low_in;
   logic [EW-1:0]        res_high_ff,  res_high_in;
   logic [SB-1:0]        diff_mag_ff,  diff_mag_in;
   logic [SB-1:0]        span_mag_ff,  span_mag_in;
   logic [SB-1:0]        top_ff,       top_in;
   logic                 neg_ff,       neg_in;

   logic signed [VW-1:0] rsp_value_ff;
   logic                 rsp_zero_ff;
   logic [EW-1:0]        rsp_low_ff;
   logic [EW-1:0]        rsp_high_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_load;

   logic [smcn_pkg::CH_IDX_W-1:0] idx;
   smcn_pkg::cal_pair_type        cal_rd;
   smcn_pkg::cal_wr_type          cal_wr;
   logic                          chan_ok;
   logic                          inv;
   logic [SB-1:0]                 x;
   logic [SB-1:0]                 new_low;
   logic [SB-1:0]                 new_high;
   logic [SB:0]                   diff;
   logic [SB:0]                   span;
   logic                          rescale;

   logic          div_start;
   logic          div_done;
   logic [NW-1:0] div_num;
   logic [NW-1:0] div_quo;
   logic [VW-1:0] quo_ext;

   assign idx     = smcn_pkg::CH_IDX_W'(req_channel);
   assign chan_ok = 32'(req_channel) < smcn_pkg::CHANNELS;
   assign inv     = chan_ok & mask_ff[idx];
   assign x       = req_sample ^ {SB{inv}};   // FULL_SCALE - sample when inverted, else the sample
   assign new_low  = (x < cal_rd.low)  ? x : cal_rd.low;
   assign new_high = (x > cal_rd.high) ? x : cal_rd.high;
   assign diff     = {1'b0, x} - {1'b0, cal_rd.low};
   assign span     = {1'b0, cal_rd.high} - {1'b0, cal_rd.low};
   assign rescale  = (scale_ff == smcn_pkg::SCALE_PCT) || (scale_ff == smcn_pkg::SCALE_FULL);
   assign div_num  = NW'(diff_mag_ff) * NW'(top_ff);
   assign quo_ext  = VW'(div_quo);

   smcn_cal_store u_cal (
      .clock (clock),
      .reset (reset),
      .idx   (idx),
      .wr    (cal_wr),
      .rd    (cal_rd)
   );

   smcn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (span_mag_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_ready = (state_ff == smcn_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_load  = (state_ff == smcn_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      res_value_in = res_value_ff;
      res_zero_in  = res_zero_ff;
      res_low_in   = res_low_ff;
      res_high_in  = res_high_ff;
      diff_mag_in  = diff_mag_ff;
      span_mag_in  = span_mag_ff;
      top_in       = top_ff;
      neg_in       = neg_ff;
      cal_wr.en    = 1'b0;
      cal_wr.pair  = cal_rd;
      div_start    = 1'b0;
      unique case (state_ff)
         smcn_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in     = smcn_pkg::ST_DONE;
               res_value_in = '0;
               res_zero_in  = 1'b0;
               res_low_in   = EW'(cal_rd.low);
               res_high_in  = EW'(cal_rd.high);
               diff_mag_in  = diff[SB] ? SB'(-diff) : diff[SB-1:0];
               span_mag_in  = span[SB] ? SB'(-span) : span[SB-1:0];
               top_in       = (scale_ff == smcn_pkg::SCALE_PCT) ? smcn_pkg::PERCENT_TOP
                                                                 : smcn_pkg::FULL_SCALE;
               neg_in       = diff[SB] ^ span[SB];
               if (!chan_ok) begin
                  res_low_in  = '0;
                  res_high_in = '0;
               end else begin
                  unique case (req_cmd)
                     smcn_pkg::CMD_TRACK: begin
                        cal_wr.en        = 1'b1;
                        cal_wr.pair.low  = new_low;
                        cal_wr.pair.high = new_high;
                        res_low_in       = EW'(new_low);
                        res_high_in      = EW'(new_high);
                     end
                     smcn_pkg::CMD_LOAD: begin
                        cal_wr.en        = 1'b1;
                        cal_wr.pair.low  = req_load_low;
                        cal_wr.pair.high = req_load_high;
                        res_low_in       = EW'(req_load_low);
                        res_high_in      = EW'(req_load_high);
                     end
                     smcn_pkg::CMD_NORM: begin
                        if (!rescale) begin
                           res_value_in = VW'(x);
                        end else if (cal_rd.high == cal_rd.low) begin
                           res_zero_in = 1'b1;
                        end else begin
                           state_in = smcn_pkg::ST_MUL;
                        end
                     end
                     smcn_pkg::CMD_NOP: begin
                     end
                  endcase
               end
            end
         end
         smcn_pkg::ST_MUL: begin
            div_start = 1'b1;
            state_in  = smcn_pkg::ST_DIV;
         end
         smcn_pkg::ST_DIV: begin
            if (div_done) begin
               // magnitude quotient, then sign: truncation toward zero
               res_value_in = neg_ff ? -quo_ext : quo_ext;
               state_in     = smcn_pkg::ST_DONE;
            end
         end
         smcn_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = smcn_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = smcn_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smcn_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= smcn_pkg::SCALE_RESET;
         mask_ff  <= smcn_pkg::MASK_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            smcn_pkg::CSR_OUTPUT_SCALE: scale_ff <= csr_wdata[1:0];
            smcn_pkg::CSR_INVERT_MASK:  mask_ff  <= csr_wdata[smcn_pkg::CHANNELS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      res_value_ff <= res_value_in;
      res_zero_ff  <= res_zero_in;
      res_low_ff   <= res_low_in;
      res_high_ff  <= res_high_in;
      diff_mag_ff  <= diff_mag_in;
      span_mag_ff  <= span_mag_in;
      top_ff       <= top_in;
      neg_ff       <= neg_in;
      if (rsp_load) begin
         rsp_value_ff <= res_value_ff;
         rsp_zero_ff  <= res_zero_ff;
         rsp_low_ff   <= res_low_ff;
         rsp_high_ff  <= res_high_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_zero_span = rsp_zero_ff;
   assign rsp_chan_low  = rsp_low_ff;
   assign rsp_chan_high = rsp_high_ff;

endmodule
